// ----- sv/cc_event_admission_filter_defines.svh -----
// Assertion macros for the congestion-control event admission filter.
`ifndef CC_EVENT_ADMISSION_FILTER_DEFINES_SVH
`define CC_EVENT_ADMISSION_FILTER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CCEAF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cceaf: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define CCEAF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cceaf: next-cycle check failed");

`endif

// ----- sv/cceaf_pkg.sv -----
// Shared types, codes and constants of the congestion-control event admission filter.
package cceaf_pkg;

  localparam int unsigned CmdW      = 3;
  localparam int unsigned ConnW     = 10;
  localparam int unsigned TimeW     = 48;
  localparam int unsigned RetxInW   = 8;
  localparam int unsigned IncW      = 8;
  localparam int unsigned RetxOutW  = 3;
  localparam int unsigned AckOutW   = 8;
  localparam int unsigned QueueW    = 12;
  localparam int unsigned GapW      = 32;
  localparam int unsigned MinAckW   = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  localparam int unsigned DefConnections  = 1024;
  localparam int unsigned DefAckCountBits = 8;

  localparam logic [RetxInW-1:0]  RetxLimit  = RetxInW'(7);
  localparam logic [RetxOutW-1:0] RetxClamp  = RetxOutW'(6);
  localparam logic [AckOutW-1:0]  AckOutMax  = '1;

  localparam logic [QueueW-1:0]  BandOneRst   = QueueW'(16);
  localparam logic [QueueW-1:0]  BandTwoRst   = QueueW'(32);
  localparam logic [QueueW-1:0]  BandThreeRst = QueueW'(48);
  localparam logic [QueueW-1:0]  CapacityRst  = QueueW'(64);
  localparam logic [GapW-1:0]    MinGapRst    = '0;
  localparam logic [MinAckW-1:0] MinAckRst    = '0;

  typedef enum logic [CmdW-1:0] {
    CMD_ACK       = 3'd0,
    CMD_NACK      = 3'd1,
    CMD_TIMEOUT   = 3'd2,
    CMD_DEQUEUE   = 3'd3,
    CMD_RESPONSE  = 3'd4,
    CMD_ADD_ACKED = 3'd5
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BAND_ONE   = 3'd0,
    CFG_BAND_TWO   = 3'd1,
    CFG_BAND_THREE = 3'd2,
    CFG_CAPACITY   = 3'd3,
    CFG_MIN_GAP    = 3'd4,
    CFG_MIN_ACKED  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [QueueW-1:0]  band_one;
    logic [QueueW-1:0]  band_two;
    logic [QueueW-1:0]  band_three;
    logic [QueueW-1:0]  capacity;
    logic [GapW-1:0]    min_gap;
    logic [MinAckW-1:0] min_acked;
  } cfg_t;

  typedef struct packed {
    logic                admitted;
    logic [AckOutW-1:0]  acked;
    logic [RetxOutW-1:0] retx;
    logic [QueueW-1:0]   level;
  } res_t;

endpackage

// ----- sv/cceaf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cceaf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/cceaf_cfg.sv -----
// Configuration register file of the admission filter.
module cceaf_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cceaf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cceaf_pkg::CfgDataW-1:0] cfg_data_i,
  output cceaf_pkg::cfg_t                cfg_o
);
  import cceaf_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BAND_ONE:   cfg_d.band_one   = cfg_data_i[QueueW-1:0];
        CFG_BAND_TWO:   cfg_d.band_two   = cfg_data_i[QueueW-1:0];
        CFG_BAND_THREE: cfg_d.band_three = cfg_data_i[QueueW-1:0];
        CFG_CAPACITY:   cfg_d.capacity   = cfg_data_i[QueueW-1:0];
        CFG_MIN_GAP:    cfg_d.min_gap    = cfg_data_i[GapW-1:0];
        CFG_MIN_ACKED:  cfg_d.min_acked  = cfg_data_i[MinAckW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.band_one   <= BandOneRst;
      cfg_q.band_two   <= BandTwoRst;
      cfg_q.band_three <= BandThreeRst;
      cfg_q.capacity   <= CapacityRst;
      cfg_q.min_gap    <= MinGapRst;
      cfg_q.min_acked  <= MinAckRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/cceaf_eval.sv -----
// Admission decision and per-connection entry update for one transaction.
module cceaf_eval #(
  parameter int unsigned Connections  = cceaf_pkg::DefConnections,
  parameter int unsigned AckCountBits = cceaf_pkg::DefAckCountBits
) (
  input  logic [cceaf_pkg::CmdW-1:0]                  cmd_i,
  input  logic [cceaf_pkg::ConnW-1:0]                 conn_i,
  input  logic [cceaf_pkg::TimeW-1:0]                 now_i,
  input  logic [cceaf_pkg::RetxInW-1:0]               retx_i,
  input  logic [cceaf_pkg::IncW-1:0]                  inc_i,
  input  logic [cceaf_pkg::QueueW-1:0]                queue_i,
  input  cceaf_pkg::cfg_t                             cfg_i,
  input  logic [cceaf_pkg::TimeW+AckCountBits+1:0]    entry_i,
  output logic [cceaf_pkg::TimeW+AckCountBits+1:0]    entry_o,
  output logic                                        we_o,
  output cceaf_pkg::res_t                             res_o
);
  import cceaf_pkg::*;

  localparam int unsigned SumW    = ((AckCountBits > AckOutW) ? AckCountBits : AckOutW) + 1;
  localparam int unsigned TimeLsb = 2 + AckCountBits;

  logic                    in_range;
  logic                    outst;
  logic                    tval;
  logic [AckCountBits-1:0] cnt;
  logic [AckCountBits-1:0] cnt_eff;
  logic [TimeW-1:0]        tlast;
  logic [TimeW-1:0]        diff;
  logic                    time_ge;
  logic                    gap_ok;
  logic                    count_ok;
  logic                    may;
  logic                    is_evt;
  logic                    admit;
  logic [SumW-1:0]         cnt_ext;
  logic [SumW-1:0]         sum;
  logic [SumW-1:0]         cnt_max;
  logic                    outst_new;
  logic                    tval_new;
  logic [AckCountBits-1:0] cnt_new;
  logic [TimeW-1:0]        time_new;

  assign in_range = 32'(conn_i) < 32'(Connections);
  assign outst    = entry_i[0];
  assign tval     = entry_i[1];
  assign cnt      = entry_i[2 +: AckCountBits];
  assign tlast    = entry_i[TimeLsb +: TimeW];

  assign cnt_eff  = (cmd_i == CMD_TIMEOUT) ? '0 : cnt;
  assign diff     = now_i - tlast;
  assign time_ge  = now_i >= tlast;
  assign gap_ok   = !tval || (time_ge ? (diff >= TimeW'(cfg_i.min_gap))
                                      : (cfg_i.min_gap == '0));
  assign count_ok = SumW'(cnt_eff) >= SumW'(cfg_i.min_acked);

  always_comb begin
    may = 1'b0;
    if (outst) begin
      may = 1'b0;
    end else if (queue_i < cfg_i.band_one) begin
      may = 1'b1;
    end else if (queue_i < cfg_i.band_two) begin
      may = gap_ok || count_ok;
    end else if (queue_i < cfg_i.band_three) begin
      may = gap_ok;
    end else if (queue_i < cfg_i.capacity) begin
      may = gap_ok && count_ok;
    end
  end

  assign is_evt  = cmd_i inside {CMD_ACK, CMD_NACK, CMD_TIMEOUT};
  assign admit   = in_range && is_evt && may;
  assign cnt_ext = SumW'(cnt);
  assign cnt_max = SumW'({AckCountBits{1'b1}});
  assign sum     = cnt_ext + SumW'(inc_i);

  always_comb begin
    outst_new = outst;
    tval_new  = tval;
    cnt_new   = cnt;
    time_new  = tlast;
    we_o      = 1'b0;
    if (in_range) begin
      case (cmd_i)
        CMD_ACK, CMD_NACK: begin
          we_o = 1'b1;
        end
        CMD_TIMEOUT: begin
          we_o    = 1'b1;
          cnt_new = '0;
        end
        CMD_RESPONSE: begin
          we_o      = 1'b1;
          outst_new = 1'b0;
        end
        CMD_ADD_ACKED: begin
          we_o    = 1'b1;
          cnt_new = (sum > cnt_max) ? cnt_max[AckCountBits-1:0] : sum[AckCountBits-1:0];
        end
        default: begin
        end
      endcase
    end
    if (admit) begin
      outst_new = 1'b1;
      tval_new  = 1'b1;
      time_new  = now_i;
      cnt_new   = '0;
    end
  end

  assign entry_o = {time_new, cnt_new, tval_new, outst_new};

  always_comb begin
    res_o.admitted = admit;
    res_o.acked    = '0;
    res_o.retx     = '0;
    if (admit && (cmd_i != CMD_TIMEOUT)) begin
      res_o.acked = (cnt_ext > SumW'(AckOutMax)) ? AckOutMax : cnt_ext[AckOutW-1:0];
    end
    if (cmd_i == CMD_TIMEOUT) begin
      res_o.retx = (retx_i >= RetxLimit) ? RetxClamp : retx_i[RetxOutW-1:0];
    end
    if (admit) begin
      res_o.level = queue_i + QueueW'(1);
    end else if ((cmd_i == CMD_DEQUEUE) && (queue_i != '0)) begin
      res_o.level = queue_i - QueueW'(1);
    end else begin
      res_o.level = queue_i;
    end
  end

endmodule

// ----- sv/cc_event_admission_filter.sv -----
// Top level of the congestion-control event admission filter.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------------
//   in      | input     | in_valid_i/in_stall_o  | command, connection, now, retx, increment
//   out     | output    | out_valid_o/out_stall_i| admitted, connection, counts, queue level
//   cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One transaction per cycle while neither the clearing pass nor a stalled result holds
// input; the input stage and RAM read are registered at acceptance, the result register
// when the input stage advances. The rate is set by the single read-modify-write of the
// connection RAM, with the last write forwarded.
// After reset a clearing pass zeroes every RAM entry in turn; in_stall_o is
// high throughout. A stalled result holds the input stage, which then stalls input.
module cc_event_admission_filter #(
  parameter int unsigned Connections  = cceaf_pkg::DefConnections,
  parameter int unsigned AckCountBits = cceaf_pkg::DefAckCountBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [cceaf_pkg::CmdW-1:0]     command_i,
  input  logic [cceaf_pkg::ConnW-1:0]    connection_i,
  input  logic [cceaf_pkg::TimeW-1:0]    now_i,
  input  logic [cceaf_pkg::RetxInW-1:0]  retransmit_count_i,
  input  logic [cceaf_pkg::IncW-1:0]     acked_increment_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           admitted_o,
  output logic [cceaf_pkg::ConnW-1:0]    event_connection_o,
  output logic [cceaf_pkg::AckOutW-1:0]  event_acked_count_o,
  output logic [cceaf_pkg::RetxOutW-1:0] event_retransmit_count_o,
  output logic [cceaf_pkg::QueueW-1:0]   queue_level_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cceaf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cceaf_pkg::CfgDataW-1:0] cfg_data_i
);
  import cceaf_pkg::*;

`include "cc_event_admission_filter_defines.svh"

  localparam int unsigned AddrW  = $clog2(Connections);
  localparam int unsigned EntryW = TimeW + AckCountBits + 2;

  cfg_t cfg;

  logic                accept;
  logic                adv;
  logic                clr_q;
  logic                clr_d;
  logic [AddrW-1:0]    clr_cnt_q;
  logic [AddrW-1:0]    clr_cnt_d;

  logic                s1_valid_q;
  logic                s1_valid_d;
  logic [CmdW-1:0]     s1_cmd_q;
  logic [ConnW-1:0]    s1_conn_q;
  logic [TimeW-1:0]    s1_now_q;
  logic [RetxInW-1:0]  s1_retx_q;
  logic [IncW-1:0]     s1_inc_q;

  logic [ConnW+AddrW-1:0] rd_conn_ext;
  logic [ConnW+AddrW-1:0] s1_conn_ext;
  logic [AddrW-1:0]    rd_addr;
  logic [AddrW-1:0]    s1_addr;

  logic [EntryW-1:0]   rdata;
  logic [EntryW-1:0]   entry_cur;
  logic [EntryW-1:0]   entry_new;
  logic                item_we;
  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr;
  logic [EntryW-1:0]   ram_wdata;

  logic                fwd_valid_q;
  logic [AddrW-1:0]    fwd_addr_q;
  logic [EntryW-1:0]   fwd_data_q;

  logic [QueueW-1:0]   queued_q;
  res_t                res;
  res_t                out_q;
  logic [ConnW-1:0]    out_conn_q;
  logic                out_valid_q;
  logic                out_valid_d;

  cceaf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Handshake: the input stage advances whenever the result register is free or drains.
  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clr_q || (s1_valid_q && !adv);
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_valid_d = accept || (s1_valid_q && !adv);

  assign rd_conn_ext = {{AddrW{1'b0}}, connection_i};
  assign s1_conn_ext = {{AddrW{1'b0}}, s1_conn_q};
  assign rd_addr     = rd_conn_ext[AddrW-1:0];
  assign s1_addr     = s1_conn_ext[AddrW-1:0];

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + AddrW'(1);
      if (clr_cnt_q == AddrW'(Connections - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  // Forward the last item write over the RAM read that missed it.
  assign entry_cur = (fwd_valid_q && (fwd_addr_q == s1_addr)) ? fwd_data_q : rdata;

  cceaf_eval #(
    .Connections  (Connections),
    .AckCountBits (AckCountBits)
  ) u_eval (
    .cmd_i   (s1_cmd_q),
    .conn_i  (s1_conn_q),
    .now_i   (s1_now_q),
    .retx_i  (s1_retx_q),
    .inc_i   (s1_inc_q),
    .queue_i (queued_q),
    .cfg_i   (cfg),
    .entry_i (entry_cur),
    .entry_o (entry_new),
    .we_o    (item_we),
    .res_o   (res)
  );

  assign ram_we    = clr_q || (adv && item_we);
  assign ram_waddr = clr_q ? clr_cnt_q : s1_addr;
  assign ram_wdata = clr_q ? '0 : entry_new;

  cceaf_ram #(
    .Width (EntryW),
    .Depth (Connections)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  assign out_valid_d = adv || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      queued_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      clr_cnt_q   <= clr_cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        queued_q <= res.level;
      end
      if (adv && item_we) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q  <= command_i;
      s1_conn_q <= connection_i;
      s1_now_q  <= now_i;
      s1_retx_q <= retransmit_count_i;
      s1_inc_q  <= acked_increment_i;
    end
    if (adv && item_we) begin
      fwd_addr_q <= s1_addr;
      fwd_data_q <= entry_new;
    end
    if (adv) begin
      out_q      <= res;
      out_conn_q <= s1_conn_q;
    end
  end

  assign out_valid_o              = out_valid_q;
  assign admitted_o               = out_q.admitted;
  assign event_connection_o       = out_conn_q;
  assign event_acked_count_o      = out_q.acked;
  assign event_retransmit_count_o = out_q.retx;
  assign queue_level_o            = out_q.level;

  `CCEAF_ASSERT_SAME(a_clear_blocks_input, clr_q, in_stall_o && !s1_valid_q)
  `CCEAF_ASSERT_NEXT(a_queue_moves_on_advance, !adv, $stable(queued_q))
  `CCEAF_ASSERT_SAME(a_admit_only_events, adv && res.admitted,
                     s1_cmd_q == CMD_ACK || s1_cmd_q == CMD_NACK || s1_cmd_q == CMD_TIMEOUT)
  `CCEAF_ASSERT_NEXT(a_result_follows_advance, adv, out_valid_o && (queue_level_o == queued_q))

endmodule

// ----- dv/cc_event_admission_filter_test.sv -----
// Self-checking testbench for the congestion-control event admission filter.
module cc_event_admission_filter_test;
  import cceaf_pkg::*;

  localparam int unsigned Conns      = DefConnections;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainWait  = 8;

  localparam logic [CmdW-1:0]    CmdSpareLo = 3'd6;
  localparam logic [CmdW-1:0]    CmdSpareHi = 3'd7;
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

  localparam logic [TimeW-1:0] TimeMax = '1;

  typedef struct packed {
    logic [CmdW-1:0]    cmd;
    logic [ConnW-1:0]   conn;
    logic [TimeW-1:0]   now;
    logic [RetxInW-1:0] retx;
    logic [IncW-1:0]    inc;
  } evt_t;

  typedef struct packed {
    logic                admitted;
    logic [ConnW-1:0]    conn;
    logic [AckOutW-1:0]  acked;
    logic [RetxOutW-1:0] retx;
    logic [QueueW-1:0]   level;
  } verdict_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [CmdW-1:0]       command_i = '0;
  logic [ConnW-1:0]      connection_i = '0;
  logic [TimeW-1:0]      now_i = '0;
  logic [RetxInW-1:0]    retransmit_count_i = '0;
  logic [IncW-1:0]       acked_increment_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  admitted_o;
  logic [ConnW-1:0]      event_connection_o;
  logic [AckOutW-1:0]    event_acked_count_o;
  logic [RetxOutW-1:0]   event_retransmit_count_o;
  logic [QueueW-1:0]     queue_level_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i = '0;
  logic [CfgDataW-1:0]   cfg_data_i = '0;

  cfg_t filt_cfg = {BandOneRst, BandTwoRst, BandThreeRst, CapacityRst, MinGapRst, MinAckRst};
  bit                  busy    [Conns];
  bit                  stamped [Conns];
  bit [TimeW-1:0]      stamp   [Conns];
  bit [AckOutW-1:0]    tally   [Conns];
  logic [QueueW-1:0]   level = '0;

  evt_t       event_q[$];
  verdict_t   verdict_q[$];
  evt_t       cur_evt;
  int         fault_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned in_pause = 0;
  int unsigned out_pause = 0;
  bit          steady_in = 1'b0;
  bit          steady_out = 1'b0;

  int unsigned      dequeue_pct = 10;
  int unsigned      step_max = 300;
  logic [TimeW-1:0] wall_ns = '0;
  logic [ConnW-1:0] hot_conn [8];

  cc_event_admission_filter u_dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .in_valid_i               (in_valid_i),
    .in_stall_o               (in_stall_o),
    .command_i                (command_i),
    .connection_i             (connection_i),
    .now_i                    (now_i),
    .retransmit_count_i       (retransmit_count_i),
    .acked_increment_i        (acked_increment_i),
    .out_valid_o              (out_valid_o),
    .out_stall_i              (out_stall_i),
    .admitted_o               (admitted_o),
    .event_connection_o       (event_connection_o),
    .event_acked_count_o      (event_acked_count_o),
    .event_retransmit_count_o (event_retransmit_count_o),
    .queue_level_o            (queue_level_o),
    .cfg_valid_i              (cfg_valid_i),
    .cfg_ready_o              (cfg_ready_o),
    .cfg_index_i              (cfg_index_i),
    .cfg_data_i               (cfg_data_i)
  );

  function automatic bit may_enqueue(logic [ConnW-1:0] c, logic [TimeW-1:0] t);
    logic [TimeW-1:0] gap;
    bit gap_ok;
    bit count_ok;
    if (busy[c]) return 1'b0;
    if (level < filt_cfg.band_one) return 1'b1;
    gap = (t >= stamp[c]) ? t - stamp[c] : '0;
    gap_ok = !stamped[c] || (gap >= TimeW'(filt_cfg.min_gap));
    count_ok = tally[c] >= filt_cfg.min_acked;
    if (level < filt_cfg.band_two) return gap_ok || count_ok;
    if (level < filt_cfg.band_three) return gap_ok;
    if (level < filt_cfg.capacity) return gap_ok && count_ok;
    return 1'b0;
  endfunction

  function automatic void stamp_admission(logic [ConnW-1:0] c, logic [TimeW-1:0] t);
    busy[c] = 1'b1;
    stamp[c] = t;
    stamped[c] = 1'b1;
    tally[c] = '0;
    level = level + 1'b1;
  endfunction

  function automatic verdict_t judge_event(evt_t e);
    verdict_t v;
    logic [AckOutW:0] sum;
    v = '0;
    v.conn = e.conn;
    if (e.cmd == CMD_TIMEOUT) begin
      v.retx = (e.retx >= RetxLimit) ? RetxClamp : e.retx[RetxOutW-1:0];
    end
    if (e.conn < Conns) begin
      case (e.cmd)
        CMD_ACK, CMD_NACK: begin
          if (may_enqueue(e.conn, e.now)) begin
            v.acked = tally[e.conn];
            stamp_admission(e.conn, e.now);
            v.admitted = 1'b1;
          end
        end
        CMD_TIMEOUT: begin
          tally[e.conn] = '0;
          if (may_enqueue(e.conn, e.now)) begin
            stamp_admission(e.conn, e.now);
            v.admitted = 1'b1;
          end
        end
        CMD_RESPONSE: busy[e.conn] = 1'b0;
        CMD_ADD_ACKED: begin
          sum = tally[e.conn] + e.inc;
          tally[e.conn] = sum[AckOutW] ? AckOutMax : sum[AckOutW-1:0];
        end
        default: ;
      endcase
    end
    if (e.cmd == CMD_DEQUEUE && level != '0) level = level - 1'b1;
    v.level = level;
    return v;
  endfunction

  function automatic int unsigned draw_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(16, 40);
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fault_cnt++;
    end
  endfunction

  function automatic evt_t make_random_event();
    evt_t e;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      e.cmd = r[0] ? CmdSpareHi : CmdSpareLo;
    end else if (r < 2 + dequeue_pct) begin
      e.cmd = CMD_DEQUEUE;
    end else if (r < 20 + dequeue_pct) begin
      e.cmd = CMD_RESPONSE;
    end else if (r < 38 + dequeue_pct) begin
      e.cmd = CMD_ADD_ACKED;
    end else begin
      case ($urandom_range(0, 2))
        0: e.cmd = CMD_ACK;
        1: e.cmd = CMD_NACK;
        default: e.cmd = CMD_TIMEOUT;
      endcase
    end
    if ($urandom_range(0, 99) < 85) e.conn = hot_conn[$urandom_range(0, 7)];
    else e.conn = ConnW'($urandom_range(0, Conns - 1));
    wall_ns = wall_ns + $urandom_range(0, step_max);
    r = $urandom_range(0, 99);
    if (r < 3) e.now = wall_ns - $urandom_range(1, 300);
    else if (r < 5) e.now = TimeW'({$urandom, $urandom});
    else e.now = wall_ns;
    e.retx = $urandom_range(0, 1) ? RetxInW'($urandom_range(0, 9)) : RetxInW'($urandom);
    e.inc = $urandom_range(0, 1) ? IncW'($urandom_range(0, 4)) : IncW'($urandom);
    return e;
  endfunction

  task automatic queue_event(logic [CmdW-1:0] cmd, logic [ConnW-1:0] conn,
                             logic [TimeW-1:0] now, logic [RetxInW-1:0] retx,
                             logic [IncW-1:0] inc);
    event_q.push_back('{cmd: cmd, conn: conn, now: now, retx: retx, inc: inc});
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_BAND_ONE:   filt_cfg.band_one = data[QueueW-1:0];
      CFG_BAND_TWO:   filt_cfg.band_two = data[QueueW-1:0];
      CFG_BAND_THREE: filt_cfg.band_three = data[QueueW-1:0];
      CFG_CAPACITY:   filt_cfg.capacity = data[QueueW-1:0];
      CFG_MIN_GAP:    filt_cfg.min_gap = data[GapW-1:0];
      CFG_MIN_ACKED:  filt_cfg.min_acked = data[MinAckW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setup(logic [CfgDataW-1:0] b1, logic [CfgDataW-1:0] b2,
                             logic [CfgDataW-1:0] b3, logic [CfgDataW-1:0] cap,
                             logic [CfgDataW-1:0] gap, logic [CfgDataW-1:0] acked);
    write_reg(CFG_BAND_ONE, b1);
    write_reg(CFG_BAND_TWO, b2);
    write_reg(CFG_BAND_THREE, b3);
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_MIN_GAP, gap);
    write_reg(CFG_MIN_ACKED, acked);
    if ($urandom_range(0, 1)) write_reg($urandom_range(0, 1) ? CfgSpareHi : CfgSpareLo, $urandom);
  endtask

  task automatic settle();
    do @(negedge clk_i); while (event_q.size() != 0 || verdict_q.size() != 0 || in_valid_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        verdict_q.push_back(judge_event(cur_evt));
        if ($urandom_range(0, 39) == 0) steady_in = !steady_in;
        in_pause = steady_in ? 0 : draw_pause();
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_pause != 0) begin
          in_valid_i <= 1'b0;
          in_pause--;
        end else if (event_q.size() != 0) begin
          cur_evt = event_q.pop_front();
          in_valid_i <= 1'b1;
          command_i <= cur_evt.cmd;
          connection_i <= cur_evt.conn;
          now_i <= cur_evt.now;
          retransmit_count_i <= cur_evt.retx;
          acked_increment_i <= cur_evt.inc;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $error("result with no pending transaction, connection %0d", event_connection_o);
          fault_cnt++;
        end else begin
          want = verdict_q.pop_front();
          compare_field("admitted", want.admitted, admitted_o);
          compare_field("event_connection", want.conn, event_connection_o);
          compare_field("event_acked_count", want.acked, event_acked_count_o);
          compare_field("event_retransmit_count", want.retx, event_retransmit_count_o);
          compare_field("queue_level", want.level, queue_level_o);
        end
        if ($urandom_range(0, 39) == 0) steady_out = !steady_out;
      end
      if (out_pause != 0) begin
        out_stall_i <= 1'b1;
        out_pause--;
      end else begin
        out_stall_i <= 1'b0;
        out_pause = steady_out ? 0 : draw_pause();
      end
    end
  end

  initial begin
    logic [CfgDataW-1:0] b1;
    logic [CfgDataW-1:0] b2;
    logic [CfgDataW-1:0] b3;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    apply_setup(1, 2, 3, 4, 100, 2);
    queue_event(CMD_ACK, 0, 1000, 0, 0);
    queue_event(CMD_ACK, 0, 1200, 0, 0);
    queue_event(CMD_ADD_ACKED, 0, 1210, 0, 255);
    queue_event(CMD_ADD_ACKED, 0, 1220, 0, 255);
    queue_event(CMD_RESPONSE, 0, 1230, 0, 0);
    queue_event(CMD_NACK, 0, 1050, 0, 0);
    queue_event(CMD_RESPONSE, 0, 1055, 0, 0);
    queue_event(CMD_TIMEOUT, 0, 1060, 255, 0);
    queue_event(CMD_RESPONSE, 1023, 1070, 0, 0);
    queue_event(CMD_TIMEOUT, 1023, 0, 7, 0);
    queue_event(CMD_TIMEOUT, 3, 5000, 6, 0);
    queue_event(CMD_ADD_ACKED, 3, 5010, 0, 2);
    queue_event(CMD_ACK, 3, TimeMax, 0, 0);
    queue_event(CMD_NACK, 4, 0, 0, 0);
    queue_event(CMD_DEQUEUE, 0, 0, 0, 0);
    queue_event(CMD_RESPONSE, 3, 6000, 0, 0);
    queue_event(CMD_ACK, 3, 2000, 0, 0);
    queue_event(CmdSpareLo, 0, 7000, 255, 255);
    queue_event(CmdSpareHi, 1023, TimeMax, 255, 255);
    queue_event(CMD_TIMEOUT, 7, 8000, 0, 0);
    repeat (4) queue_event(CMD_DEQUEUE, 1023, TimeMax, 0, 0);
    settle();

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: apply_setup(16, 32, 48, 64, 150, 3);
        1: apply_setup(2, 4, 6, 8, 300, 5);
        2: apply_setup(0, 0, 0, 0, 0, 0);
        3: apply_setup(4095, 4095, 4095, 4095, 32'hFFFF_FFFF, 255);
        4: apply_setup(10, 3, 5, 7, 100, 1);
        5: apply_setup(0, 6, 12, 20, 500, 10);
        6: apply_setup(0, 4095, 0, 0, 32'hFFFF_FFFF, 255);
        7: begin
          b1 = $urandom_range(0, 8);
          b2 = b1 + $urandom_range(0, 8);
          b3 = b2 + $urandom_range(0, 8);
          apply_setup(b1, b2, b3, b3 + $urandom_range(0, 8), $urandom_range(0, 800),
                      $urandom_range(0, 8));
        end
        default: apply_setup($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      case ($urandom_range(0, 3))
        0: dequeue_pct = 5;
        1: dequeue_pct = 12;
        2: dequeue_pct = 20;
        default: dequeue_pct = 25;
      endcase
      step_max = $urandom_range(50, 600);
      foreach (hot_conn[i]) hot_conn[i] = ConnW'($urandom_range(0, Conns - 1));
      repeat (160) event_q.push_back(make_random_event());
      settle();
    end

    repeat (DrainWait) @(posedge clk_i);
    if (fault_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
